### hdl/aic_pkg.sv
// aic_pkg: shared types and codes for the irrigation controller
// no dependencies; used by every module under hdl
package aic_pkg;

  localparam int unsigned TempW  = 12;
  localparam int unsigned MoistW = 10;
  localparam int unsigned FlowW  = 14;
  localparam int unsigned SecW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOIST_LOW  = 3'd0,
    CFG_MOIST_HIGH = 3'd1,
    CFG_MOIST_GOOD = 3'd2,
    CFG_TEMP_HIGH  = 3'd3,
    CFG_COOLDOWN   = 3'd4,
    CFG_MAX_WATER  = 3'd5,
    CFG_MIN_FLOW   = 3'd6
  } cfg_idx_e;

  localparam logic [StatW-1:0] STATUS_NORMAL      = 3'd0;
  localparam logic [StatW-1:0] STATUS_WATERING    = 3'd1;
  localparam logic [StatW-1:0] STATUS_MOIST_ALERT = 3'd2;
  localparam logic [StatW-1:0] STATUS_TEMP_ALERT  = 3'd3;
  localparam logic [StatW-1:0] STATUS_FLOW_LOW    = 3'd4;
  localparam logic [StatW-1:0] STATUS_ERROR       = 3'd5;

  localparam logic [CmdW-1:0] CMD_NONE = 2'd0;
  localparam logic [CmdW-1:0] CMD_ON   = 2'd1;
  localparam logic [CmdW-1:0] CMD_OFF  = 2'd2;

  typedef enum logic [5:0] {
    ST_NORMAL      = 6'b000001,
    ST_WATERING    = 6'b000010,
    ST_MOIST_ALERT = 6'b000100,
    ST_TEMP_ALERT  = 6'b001000,
    ST_FLOW_LOW    = 6'b010000,
    ST_ERROR       = 6'b100000
  } state_e;

  typedef struct packed {
    logic        [MoistW-1:0] moist_low;
    logic        [MoistW-1:0] moist_high;
    logic        [MoistW-1:0] moist_good;
    logic signed [TempW-1:0]  temp_high;
    logic        [SecW-1:0]   cooldown;
    logic        [SecW-1:0]   max_water;
    logic        [FlowW-1:0]  min_flow;
  } cfg_t;

  // classified tick, as it travels from front to back
  typedef struct packed {
    logic             fault;
    logic             moist_below;
    logic             temp_above;
    logic             flow_low;
    logic             moist_over;
    logic             recovered;
    logic             running;
    logic             write_ok;
    logic [TimeW-1:0] now;
  } item_t;

  function automatic logic [StatW-1:0] status_code(state_e st);
    logic [StatW-1:0] code;
    case (st)
      ST_NORMAL:      code = STATUS_NORMAL;
      ST_WATERING:    code = STATUS_WATERING;
      ST_MOIST_ALERT: code = STATUS_MOIST_ALERT;
      ST_TEMP_ALERT:  code = STATUS_TEMP_ALERT;
      ST_FLOW_LOW:    code = STATUS_FLOW_LOW;
      ST_ERROR:       code = STATUS_ERROR;
      default:        code = STATUS_NORMAL;
    endcase
    return code;
  endfunction

endpackage

### hdl/auto_irrigation_controller.sv
// auto_irrigation_controller: top level, config registers, front, queue and back
// depends on aic_pkg, aic_front, aic_queue, aic_back
//
//  channel | handshake             | carries
//  --------+-----------------------+------------------------------------------
//  in      | in_valid_i/in_stall_o | one sensor tick per transaction
//  out     | out_valid_o/out_stall_i | status, pump command, leds, lock flag
//  cfg     | cfg_valid_i/cfg_ready_o | register index and write data
//
// one tick per cycle sustained while out_stall_i is low; a tick enters the queue at its
// accept edge and its result is registered when the back end takes it from the queue.
// the queue lets the input side keep accepting while the result register waits on
// out_stall_i. reset clears status to normal, lock and timestamps to zero and loads
// the config defaults; cfg_ready_o is always high.
module auto_irrigation_controller #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [aic_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [aic_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [aic_pkg::TempW-1:0]    temperature_i,
  input  logic                                temperature_valid_i,
  input  logic        [aic_pkg::MoistW-1:0]   moisture_i,
  input  logic                                moisture_valid_i,
  input  logic        [aic_pkg::FlowW-1:0]    flow_rate_i,
  input  logic                                pump_running_i,
  input  logic        [aic_pkg::TimeW-1:0]    now_seconds_i,
  input  logic                                pump_write_ok_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [aic_pkg::StatW-1:0]    status_o,
  output logic        [aic_pkg::CmdW-1:0]     pump_command_o,
  output logic                                led_green_o,
  output logic                                led_yellow_o,
  output logic                                led_red_o,
  output logic                                yellow_blink_o,
  output logic                                pump_locked_out_o
);

  aic_pkg::cfg_t cfg_q;
  aic_pkg::item_t front_item, queue_item;
  logic queue_full, queue_empty, back_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = queue_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.moist_low  <= 10'd300;
      cfg_q.moist_high <= 10'd800;
      cfg_q.moist_good <= 10'd600;
      cfg_q.temp_high  <= 12'sd350;
      cfg_q.cooldown   <= 16'd60;
      cfg_q.max_water  <= 16'd30;
      cfg_q.min_flow   <= 14'd10;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        aic_pkg::CFG_MOIST_LOW:  cfg_q.moist_low  <= cfg_data_i[aic_pkg::MoistW-1:0];
        aic_pkg::CFG_MOIST_HIGH: cfg_q.moist_high <= cfg_data_i[aic_pkg::MoistW-1:0];
        aic_pkg::CFG_MOIST_GOOD: cfg_q.moist_good <= cfg_data_i[aic_pkg::MoistW-1:0];
        aic_pkg::CFG_TEMP_HIGH:  cfg_q.temp_high  <= $signed(cfg_data_i[aic_pkg::TempW-1:0]);
        aic_pkg::CFG_COOLDOWN:   cfg_q.cooldown   <= cfg_data_i;
        aic_pkg::CFG_MAX_WATER:  cfg_q.max_water  <= cfg_data_i;
        aic_pkg::CFG_MIN_FLOW:   cfg_q.min_flow   <= cfg_data_i[aic_pkg::FlowW-1:0];
        default: ;
      endcase
    end
  end

  aic_front u_front (
    .cfg_i               (cfg_q),
    .temperature_i       (temperature_i),
    .temperature_valid_i (temperature_valid_i),
    .moisture_i          (moisture_i),
    .moisture_valid_i    (moisture_valid_i),
    .flow_rate_i         (flow_rate_i),
    .pump_running_i      (pump_running_i),
    .now_seconds_i       (now_seconds_i),
    .pump_write_ok_i     (pump_write_ok_i),
    .item_o              (front_item)
  );

  aic_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (back_take),
    .empty_o     (queue_empty),
    .pop_item_o  (queue_item)
  );

  aic_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .item_valid_i      (!queue_empty),
    .item_i            (queue_item),
    .item_take_o       (back_take),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .pump_command_o    (pump_command_o),
    .led_green_o       (led_green_o),
    .led_yellow_o      (led_yellow_o),
    .led_red_o         (led_red_o),
    .yellow_blink_o    (yellow_blink_o),
    .pump_locked_out_o (pump_locked_out_o)
  );

`ifndef ASSERT_OFF
  a_red_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (led_red_o == ((status_o == aic_pkg::STATUS_FLOW_LOW) ||
                                   (status_o == aic_pkg::STATUS_ERROR))))
    else $error("red led disagrees with status");

  a_on_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pump_command_o == aic_pkg::CMD_ON) |->
      (status_o != aic_pkg::STATUS_NORMAL && status_o != aic_pkg::STATUS_FLOW_LOW))
    else $error("drive on with normal or flow low status");

  a_blink_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yellow_blink_o == (led_green_o && led_yellow_o)) &&
                    (led_green_o || led_yellow_o || led_red_o))
    else $error("led pattern inconsistent");
`endif

endmodule

### hdl/aic_front.sv
// aic_front: compares one sensor tick against the configured limits
// depends on aic_pkg
module aic_front (
  input  aic_pkg::cfg_t                       cfg_i,
  input  logic signed [aic_pkg::TempW-1:0]    temperature_i,
  input  logic                                temperature_valid_i,
  input  logic        [aic_pkg::MoistW-1:0]   moisture_i,
  input  logic                                moisture_valid_i,
  input  logic        [aic_pkg::FlowW-1:0]    flow_rate_i,
  input  logic                                pump_running_i,
  input  logic        [aic_pkg::TimeW-1:0]    now_seconds_i,
  input  logic                                pump_write_ok_i,
  output aic_pkg::item_t                      item_o
);

  logic temp_above;

  assign temp_above = temperature_i > cfg_i.temp_high;

  always_comb begin
    item_o.fault       = !(temperature_valid_i && moisture_valid_i);
    item_o.moist_below = moisture_i < cfg_i.moist_low;
    item_o.temp_above  = temp_above;
    item_o.flow_low    = flow_rate_i <= cfg_i.min_flow;
    item_o.moist_over  = moisture_i > cfg_i.moist_high;
    item_o.recovered   = (moisture_i >= cfg_i.moist_good) && !temp_above;
    item_o.running     = pump_running_i;
    item_o.write_ok    = pump_write_ok_i;
    item_o.now         = now_seconds_i;
  end

endmodule

### hdl/aic_queue.sv
// aic_queue: small fifo of classified ticks between front and back
// depends on aic_pkg
module aic_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  aic_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output aic_pkg::item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  aic_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o     = count_q == FullCnt;
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hdl/aic_back.sv
// aic_back: status, cooldown lock and timestamps; decides pump command and leds
// depends on aic_pkg
module aic_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aic_pkg::cfg_t                 cfg_i,
  input  logic                          item_valid_i,
  input  aic_pkg::item_t                item_i,
  output logic                          item_take_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [aic_pkg::StatW-1:0]     status_o,
  output logic [aic_pkg::CmdW-1:0]      pump_command_o,
  output logic                          led_green_o,
  output logic                          led_yellow_o,
  output logic                          led_red_o,
  output logic                          yellow_blink_o,
  output logic                          pump_locked_out_o
);

  aic_pkg::state_e st_q, st_d;
  logic lock_q, lock_d;
  logic [aic_pkg::TimeW-1:0] lock_time_q, lock_time_d, start_time_q, start_time_d;
  logic [aic_pkg::TimeW-1:0] since_lock, since_start;
  logic [aic_pkg::CmdW-1:0] cmd;
  logic g, y, r, alert;

  logic out_valid_q;
  logic [aic_pkg::StatW-1:0] status_q;
  logic [aic_pkg::CmdW-1:0] cmd_q;
  logic g_q, y_q, r_q, locked_q;

  assign item_take_o = item_valid_i && (!out_valid_q || !out_stall_i);
  assign since_lock  = item_i.now - lock_time_q;
  assign since_start = item_i.now - start_time_q;

  always_comb begin
    st_d         = st_q;
    lock_d       = lock_q;
    lock_time_d  = lock_time_q;
    start_time_d = start_time_q;
    cmd          = aic_pkg::CMD_NONE;
    alert        = 1'b0;
    if (item_i.fault) begin
      st_d = aic_pkg::ST_ERROR;
    end else begin
      if (item_i.moist_below && st_d != aic_pkg::ST_WATERING) begin
        st_d = aic_pkg::ST_MOIST_ALERT;
      end
      if (item_i.temp_above && st_d != aic_pkg::ST_WATERING) begin
        st_d = aic_pkg::ST_TEMP_ALERT;
      end
      if (item_i.flow_low) begin
        st_d = aic_pkg::ST_FLOW_LOW;
        if (item_i.running) begin
          cmd = aic_pkg::CMD_OFF;
          if (!item_i.write_ok) begin
            st_d = aic_pkg::ST_ERROR;
          end
        end
      end else begin
        if (lock_q && since_lock >= {16'd0, cfg_i.cooldown}) begin
          lock_d = 1'b0;
        end
        if (st_d == aic_pkg::ST_WATERING) begin
          if (item_i.moist_over) begin
            cmd  = aic_pkg::CMD_OFF;
            st_d = item_i.write_ok ? aic_pkg::ST_NORMAL : aic_pkg::ST_ERROR;
          end else if (since_start >= {16'd0, cfg_i.max_water} || item_i.recovered) begin
            cmd         = aic_pkg::CMD_OFF;
            st_d        = item_i.write_ok ? aic_pkg::ST_NORMAL : aic_pkg::ST_ERROR;
            lock_d      = 1'b1;
            lock_time_d = item_i.now;
          end else begin
            cmd = aic_pkg::CMD_ON;
            if (!item_i.write_ok) begin
              st_d = aic_pkg::ST_ERROR;
            end
          end
        end else begin
          alert = (st_d == aic_pkg::ST_MOIST_ALERT) || (st_d == aic_pkg::ST_TEMP_ALERT);
          if (alert && !lock_d) begin
            cmd = aic_pkg::CMD_ON;
            if (item_i.write_ok) begin
              st_d         = aic_pkg::ST_WATERING;
              start_time_d = item_i.now;
            end
          end else if (!alert && item_i.running) begin
            cmd = aic_pkg::CMD_OFF;
          end
        end
      end
    end
  end

  always_comb begin
    case (st_d)
      aic_pkg::ST_FLOW_LOW, aic_pkg::ST_ERROR: begin
        g = 1'b0; y = 1'b0; r = 1'b1;
      end
      aic_pkg::ST_WATERING: begin
        g = 1'b0; y = 1'b1; r = 1'b0;
      end
      aic_pkg::ST_MOIST_ALERT, aic_pkg::ST_TEMP_ALERT: begin
        g = 1'b1; y = 1'b1; r = 1'b0;
      end
      default: begin
        g = 1'b1; y = 1'b0; r = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= aic_pkg::ST_NORMAL;
      lock_q       <= 1'b0;
      lock_time_q  <= '0;
      start_time_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (item_take_o) begin
        st_q         <= st_d;
        lock_q       <= lock_d;
        lock_time_q  <= lock_time_d;
        start_time_q <= start_time_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      status_q <= aic_pkg::status_code(st_d);
      cmd_q    <= cmd;
      g_q      <= g;
      y_q      <= y;
      r_q      <= r;
      locked_q <= lock_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign pump_command_o    = cmd_q;
  assign led_green_o       = g_q;
  assign led_yellow_o      = y_q;
  assign led_red_o         = r_q;
  assign yellow_blink_o    = g_q && y_q;
  assign pump_locked_out_o = locked_q;

endmodule

### bench/aic_outcome_check.sv
// aic_outcome_check: watches the config, tick and result channels of the irrigation
// controller, predicts each result from its own copy of status, lock and limits, compares
// depends on aic_pkg
module aic_outcome_check
  import aic_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic        [CfgIdxW-1:0]   cfg_index_i,
  input  logic        [CfgDataW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic signed [TempW-1:0]     temperature_i,
  input  logic                        temperature_valid_i,
  input  logic        [MoistW-1:0]    moisture_i,
  input  logic                        moisture_valid_i,
  input  logic        [FlowW-1:0]     flow_rate_i,
  input  logic                        pump_running_i,
  input  logic        [TimeW-1:0]     now_seconds_i,
  input  logic                        pump_write_ok_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic        [StatW-1:0]     status_i,
  input  logic        [CmdW-1:0]      pump_command_i,
  input  logic                        led_green_i,
  input  logic                        led_yellow_i,
  input  logic                        led_red_i,
  input  logic                        yellow_blink_i,
  input  logic                        pump_locked_out_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [CmdW-1:0]  cmd;
    logic             green;
    logic             yellow;
    logic             red;
    logic             blink;
    logic             locked;
  } outcome_t;

  cfg_t             limits;
  logic [StatW-1:0] plant_status;
  logic             lock_on;
  logic [TimeW-1:0] lock_stamp;
  logic [TimeW-1:0] start_stamp;
  outcome_t         expected_outcomes[$];
  outcome_t         got;
  outcome_t         want;
  int unsigned      mismatches;
  int unsigned      checked;

  function automatic outcome_t next_tick_outcome(
    logic signed [TempW-1:0] temp,
    logic                    temp_ok,
    logic [MoistW-1:0]       moist,
    logic                    moist_ok,
    logic [FlowW-1:0]        flow,
    logic                    running,
    logic [TimeW-1:0]        now,
    logic                    write_ok
  );
    outcome_t o;
    logic     too_hot;
    logic     elapsed;
    logic     recovered;
    logic     alert;
    o = '0;
    o.cmd = CMD_NONE;
    too_hot = temp > $signed(limits.temp_high);
    if (!temp_ok || !moist_ok) begin
      plant_status = STATUS_ERROR;
    end else begin
      if (moist < limits.moist_low && plant_status != STATUS_WATERING) begin
        plant_status = STATUS_MOIST_ALERT;
      end
      if (too_hot && plant_status != STATUS_WATERING) begin
        plant_status = STATUS_TEMP_ALERT;
      end
      if (flow <= limits.min_flow) begin
        plant_status = STATUS_FLOW_LOW;
        if (running) begin
          o.cmd = CMD_OFF;
          if (!write_ok) plant_status = STATUS_ERROR;
        end
      end else begin
        if (lock_on && (now - lock_stamp) >= {16'd0, limits.cooldown}) lock_on = 1'b0;
        if (plant_status == STATUS_WATERING) begin
          elapsed = (now - start_stamp) >= {16'd0, limits.max_water};
          recovered = moist >= limits.moist_good && !too_hot;
          if (moist > limits.moist_high) begin
            o.cmd = CMD_OFF;
            plant_status = write_ok ? STATUS_NORMAL : STATUS_ERROR;
          end else if (elapsed || recovered) begin
            o.cmd = CMD_OFF;
            plant_status = write_ok ? STATUS_NORMAL : STATUS_ERROR;
            lock_on = 1'b1;
            lock_stamp = now;
          end else begin
            o.cmd = CMD_ON;
            if (!write_ok) plant_status = STATUS_ERROR;
          end
        end else begin
          alert = plant_status == STATUS_MOIST_ALERT || plant_status == STATUS_TEMP_ALERT;
          if (alert && !lock_on) begin
            o.cmd = CMD_ON;
            if (write_ok) begin
              plant_status = STATUS_WATERING;
              start_stamp = now;
            end
          end else if (!alert && running) begin
            o.cmd = CMD_OFF;
          end
        end
      end
    end
    case (plant_status)
      STATUS_FLOW_LOW, STATUS_ERROR:         {o.green, o.yellow, o.red} = 3'b001;
      STATUS_WATERING:                       {o.green, o.yellow, o.red} = 3'b010;
      STATUS_MOIST_ALERT, STATUS_TEMP_ALERT: {o.green, o.yellow, o.red} = 3'b110;
      default:                               {o.green, o.yellow, o.red} = 3'b100;
    endcase
    o.status = plant_status;
    o.blink = o.green & o.yellow;
    o.locked = lock_on;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits.moist_low  = 10'd300;
      limits.moist_high = 10'd800;
      limits.moist_good = 10'd600;
      limits.temp_high  = 12'sd350;
      limits.cooldown   = 16'd60;
      limits.max_water  = 16'd30;
      limits.min_flow   = 14'd10;
      plant_status = STATUS_NORMAL;
      lock_on = 1'b0;
      lock_stamp = '0;
      start_stamp = '0;
      expected_outcomes.delete();
      mismatches = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MOIST_LOW:  limits.moist_low  = cfg_data_i[MoistW-1:0];
          CFG_MOIST_HIGH: limits.moist_high = cfg_data_i[MoistW-1:0];
          CFG_MOIST_GOOD: limits.moist_good = cfg_data_i[MoistW-1:0];
          CFG_TEMP_HIGH:  limits.temp_high  = cfg_data_i[TempW-1:0];
          CFG_COOLDOWN:   limits.cooldown   = cfg_data_i[SecW-1:0];
          CFG_MAX_WATER:  limits.max_water  = cfg_data_i[SecW-1:0];
          CFG_MIN_FLOW:   limits.min_flow   = cfg_data_i[FlowW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = {status_i, pump_command_i, led_green_i, led_yellow_i, led_red_i,
               yellow_blink_i, pump_locked_out_i};
        checked++;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%t: result %0d with no tick waiting: status %0d cmd %0d", $realtime,
                     checked, got.status, got.cmd);
          end
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%t: result %0d expected/actual: status %0d/%0d cmd %0d/%0d ",
                     $realtime, checked, want.status, got.status, want.cmd, got.cmd);
              $display("leds %b%b%b/%b%b%b blink %b/%b lock %b/%b",
                       want.green, want.yellow, want.red, got.green, got.yellow, got.red,
                       want.blink, got.blink, want.locked, got.locked);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_outcomes.push_back(next_tick_outcome(temperature_i, temperature_valid_i,
          moisture_i, moisture_valid_i, flow_rate_i, pump_running_i, now_seconds_i,
          pump_write_ok_i));
      end
      fail_count_o <= mismatches;
      pending_o <= expected_outcomes.size();
      checked_o <= checked;
    end
  end

endmodule

### bench/auto_irrigation_controller_test.sv
// auto_irrigation_controller_test: drives sensor ticks and register writes into the
// controller under random idling on both channels and reports the verdict
// depends on aic_pkg, auto_irrigation_controller and aic_outcome_check
module auto_irrigation_controller_test;
  timeunit 1ns;
  timeprecision 1ps;
  import aic_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  typedef enum logic [1:0] {EP_CYCLE, EP_HOT, EP_NOISE} episode_e;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic        [CfgIdxW-1:0]  cfg_index_i = '0;
  logic        [CfgDataW-1:0] cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic signed [TempW-1:0]    temperature_i = '0;
  logic                       temperature_valid_i = 1'b0;
  logic        [MoistW-1:0]   moisture_i = '0;
  logic                       moisture_valid_i = 1'b0;
  logic        [FlowW-1:0]    flow_rate_i = '0;
  logic                       pump_running_i = 1'b0;
  logic        [TimeW-1:0]    now_seconds_i = '0;
  logic                       pump_write_ok_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic        [StatW-1:0]    status_o;
  logic        [CmdW-1:0]     pump_command_o;
  logic                       led_green_o;
  logic                       led_yellow_o;
  logic                       led_red_o;
  logic                       yellow_blink_o;
  logic                       pump_locked_out_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned ticks_sent = 0;
  int unsigned reg_writes = 0;
  cfg_t        mirror;
  logic [TimeW-1:0] clock_now;
  episode_e    episode;
  int          episode_left = 0;
  int          episode_step = 0;

  auto_irrigation_controller uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .temperature_i, .temperature_valid_i, .moisture_i,
    .moisture_valid_i, .flow_rate_i, .pump_running_i, .now_seconds_i, .pump_write_ok_i,
    .out_valid_o, .out_stall_i, .status_o, .pump_command_o, .led_green_o, .led_yellow_o,
    .led_red_o, .yellow_blink_o, .pump_locked_out_o
  );

  aic_outcome_check outcome_check (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .temperature_i, .temperature_valid_i, .moisture_i,
    .moisture_valid_i, .flow_rate_i, .pump_running_i, .now_seconds_i, .pump_write_ok_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .pump_command_i(pump_command_o), .led_green_i(led_green_o), .led_yellow_i(led_yellow_o),
    .led_red_i(led_red_o), .yellow_blink_i(yellow_blink_o),
    .pump_locked_out_i(pump_locked_out_o), .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= $urandom_range(99) < recv_idle_pct;
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("auto_irrigation_controller_test NOT OK");
      $finish;
    end
  end

  function automatic int pick(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  task automatic send_tick(
    logic signed [TempW-1:0] temp,
    logic                    temp_ok,
    logic [MoistW-1:0]       moist,
    logic                    moist_ok,
    logic [FlowW-1:0]        flow,
    logic                    running,
    logic [TimeW-1:0]        now,
    logic                    write_ok
  );
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    temperature_i <= temp;
    temperature_valid_i <= temp_ok;
    moisture_i <= moist;
    moisture_valid_i <= moist_ok;
    flow_rate_i <= flow;
    pump_running_i <= running;
    now_seconds_i <= now;
    pump_write_ok_i <= write_ok;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ticks_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_writes++;
    case (cfg_idx_e'(idx))
      CFG_MOIST_LOW:  mirror.moist_low  = data[MoistW-1:0];
      CFG_MOIST_HIGH: mirror.moist_high = data[MoistW-1:0];
      CFG_MOIST_GOOD: mirror.moist_good = data[MoistW-1:0];
      CFG_TEMP_HIGH:  mirror.temp_high  = data[TempW-1:0];
      CFG_COOLDOWN:   mirror.cooldown   = data[SecW-1:0];
      CFG_MAX_WATER:  mirror.max_water  = data[SecW-1:0];
      CFG_MIN_FLOW:   mirror.min_flow   = data[FlowW-1:0];
      default: ;
    endcase
  endtask

  // all results in and nothing left in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure_moderate();
    int lo;
    int hi;
    lo = pick(50, 500);
    hi = pick(600, 1000);
    write_reg(CFG_MOIST_LOW, CfgDataW'(lo));
    write_reg(CFG_MOIST_HIGH, CfgDataW'(hi));
    write_reg(CFG_MOIST_GOOD, CfgDataW'(pick(lo, hi)));
    write_reg(CFG_TEMP_HIGH, CfgDataW'(pick(-400, 1250)));
    write_reg(CFG_COOLDOWN, CfgDataW'(pick(0, 40)));
    write_reg(CFG_MAX_WATER, CfgDataW'(pick(0, 40)));
    write_reg(CFG_MIN_FLOW, CfgDataW'(pick(0, 200)));
    if ($urandom_range(1)) write_reg(CfgUnused, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure_floor();
    write_reg(CFG_MOIST_LOW, 16'h0000);
    write_reg(CFG_MOIST_HIGH, 16'h0000);
    write_reg(CFG_MOIST_GOOD, 16'h0000);
    write_reg(CFG_TEMP_HIGH, 16'h0800);
    write_reg(CFG_COOLDOWN, 16'h0000);
    write_reg(CFG_MAX_WATER, 16'h0000);
    write_reg(CFG_MIN_FLOW, 16'h0000);
    write_reg(CfgUnused, 16'h0000);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure_ceiling();
    write_reg(CFG_MOIST_LOW, 16'hFFFF);
    write_reg(CFG_MOIST_HIGH, 16'hFFFF);
    write_reg(CFG_MOIST_GOOD, 16'hFFFF);
    write_reg(CFG_TEMP_HIGH, 16'hF7FF);
    write_reg(CFG_COOLDOWN, 16'hFFFF);
    write_reg(CFG_MAX_WATER, 16'hFFFF);
    write_reg(CFG_MIN_FLOW, 16'hFFFF);
    write_reg(CfgUnused, 16'hFFFF);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure_raw();
    write_reg(CFG_MOIST_LOW, CfgDataW'($urandom));
    write_reg(CFG_MOIST_HIGH, CfgDataW'($urandom));
    write_reg(CFG_MOIST_GOOD, CfgDataW'($urandom));
    write_reg(CFG_TEMP_HIGH, CfgDataW'($urandom));
    write_reg(CFG_COOLDOWN, CfgDataW'($urandom));
    write_reg(CFG_MAX_WATER, CfgDataW'($urandom));
    write_reg(CFG_MIN_FLOW, CfgDataW'($urandom));
    write_reg(CfgUnused, CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // dry spells followed by rising moisture, hot spells, and plain noise
  task automatic random_tick();
    logic signed [TempW-1:0] temp;
    logic [MoistW-1:0]       moist;
    logic [FlowW-1:0]        flow;
    logic                    temp_ok;
    logic                    moist_ok;
    logic                    running;
    logic                    write_ok;
    int                      th;
    int                      lo;
    int                      hi;
    int                      gd;
    int                      mf;
    int                      r;
    th = int'(mirror.temp_high);
    lo = int'(mirror.moist_low);
    hi = int'(mirror.moist_high);
    gd = int'(mirror.moist_good);
    mf = int'(mirror.min_flow);
    if (episode_left == 0) begin
      r = $urandom_range(99);
      episode = (r < 60) ? EP_CYCLE : (r < 75) ? EP_HOT : EP_NOISE;
      episode_left = $urandom_range(20, 6);
      episode_step = 0;
    end
    episode_left--;
    episode_step++;
    clock_now += $urandom_range(3);
    temp_ok = $urandom_range(49) != 0;
    moist_ok = $urandom_range(49) != 0;
    running = $urandom_range(1) != 0;
    write_ok = $urandom_range(9) != 0;
    if ($urandom_range(19) == 0) flow = FlowW'(pick(0, mf));
    else flow = FlowW'(pick((mf < 16383) ? mf + 1 : mf, 16383));
    temp = TempW'(pick((th > -1448) ? th - 600 : -2048, th));
    moist = MoistW'(pick(lo, (gd > lo) ? gd - 1 : lo));
    case (episode)
      EP_CYCLE: begin
        r = $urandom_range(99);
        if (episode_step <= 2) moist = MoistW'(pick(0, lo - 1));
        else if (r < 15) moist = MoistW'(pick(gd, hi));
        else if (r < 20) moist = MoistW'(pick((hi < 1023) ? hi + 1 : hi, 1023));
      end
      EP_HOT: begin
        temp = TempW'(pick((th < 2047) ? th + 1 : th, 2047));
      end
      default: begin
        temp = TempW'($urandom);
        moist = MoistW'($urandom);
        flow = FlowW'($urandom);
        temp_ok = 1'($urandom);
        moist_ok = 1'($urandom);
        if ($urandom_range(4) == 0) clock_now = $urandom;
        else clock_now += $urandom_range(200);
      end
    endcase
    send_tick(temp, temp_ok, moist, moist_ok, flow, running, clock_now, write_ok);
  endtask

  initial begin
    mirror.moist_low  = 10'd300;
    mirror.moist_high = 10'd800;
    mirror.moist_good = 10'd600;
    mirror.temp_high  = 12'sd350;
    mirror.cooldown   = 16'd60;
    mirror.max_water  = 16'd30;
    mirror.min_flow   = 14'd10;
    clock_now = $urandom;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 30;
    recv_idle_pct = 51;

    // sensor faults, low flow, sticky status
    send_tick(200, 1'b0, 500, 1'b1, 500, 1'b0, 100, 1'b1);
    send_tick(200, 1'b1, 500, 1'b0, 500, 1'b1, 101, 1'b1);
    send_tick(200, 1'b1, 500, 1'b1, 0, 1'b1, 102, 1'b0);
    send_tick(200, 1'b1, 500, 1'b1, 10, 1'b1, 103, 1'b1);
    send_tick(200, 1'b1, 500, 1'b1, 10, 1'b0, 104, 1'b0);
    send_tick(200, 1'b1, 500, 1'b1, 11, 1'b1, 105, 1'b1);
    // failed start, start, alert during watering, failed keep-on
    send_tick(200, 1'b1, 299, 1'b1, 500, 1'b1, 106, 1'b0);
    send_tick(200, 1'b1, 299, 1'b1, 500, 1'b0, 107, 1'b1);
    send_tick(200, 1'b1, 100, 1'b1, 500, 1'b1, 110, 1'b1);
    send_tick(200, 1'b1, 400, 1'b1, 500, 1'b1, 111, 1'b0);
    // hot start, flood stop, timeout with failed ack, lockout and its expiry
    send_tick(2047, 1'b1, 400, 1'b1, 16383, 1'b1, 112, 1'b1);
    send_tick(2047, 1'b1, 1023, 1'b1, 500, 1'b1, 113, 1'b1);
    send_tick(-2048, 1'b1, 0, 1'b1, 500, 1'b1, 114, 1'b1);
    send_tick(-2048, 1'b1, 0, 1'b1, 500, 1'b1, 144, 1'b0);
    send_tick(200, 1'b1, 0, 1'b1, 500, 1'b0, 150, 1'b1);
    send_tick(200, 1'b1, 0, 1'b1, 500, 1'b0, 203, 1'b1);
    send_tick(200, 1'b1, 0, 1'b1, 500, 1'b0, 204, 1'b1);
    send_tick(200, 1'b1, 600, 1'b1, 500, 1'b1, 205, 1'b1);
    send_tick(200, 1'b1, 800, 1'b1, 500, 1'b1, 300, 1'b1);
    // run across the 32-bit wrap of the seconds counter
    send_tick(200, 1'b1, 299, 1'b1, 500, 1'b1, 32'hFFFF_FFF0, 1'b1);
    send_tick(200, 1'b1, 500, 1'b1, 500, 1'b1, 32'h0000_000D, 1'b1);
    send_tick(200, 1'b1, 500, 1'b1, 500, 1'b1, 32'h0000_000E, 1'b1);
    send_tick(351, 1'b1, 500, 1'b1, 500, 1'b0, 32'h0000_0010, 1'b1);
    send_tick(350, 1'b1, 500, 1'b1, 500, 1'b0, 32'h0000_0050, 1'b1);

    for (int seg = 0; seg < 8; seg++) begin
      settle();
      if (seg == 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 30;
      end else if (seg == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: ;
        2: configure_floor();
        3: configure_ceiling();
        7: configure_raw();
        default: configure_moderate();
      endcase
      if (seg == 5) clock_now = 32'hFFFF_FF00;
      episode_left = 0;
      repeat ((seg == 3) ? 50 : 150) random_tick();
    end
    settle();
    repeat (10) @(posedge clk_i);

    $display("sent %0d sensor ticks over eight limit settings with %0d register writes,",
             ticks_sent, reg_writes);
    $display("checked %0d results, %0d failures, in %0d cycles", checked, fail_count, cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("auto_irrigation_controller_test OK");
    end else begin
      $display("auto_irrigation_controller_test NOT OK");
    end
    $finish;
  end

endmodule
